@@ sv/fds_pkg.sv @@
// Shared types, constants and decode helpers for the Forth data stack.
// No dependencies; every other file of the block imports this package.
package fds_pkg;

   // Default sizes and fixed field widths
   localparam int STACK_DEPTH_DEF = 16;
   localparam int WORD_WIDTH_DEF  = 32;
   localparam int MODE_W          = 4;
   localparam int DATA_W          = 32;
   localparam int STATUS_W        = 2;
   localparam int DEPTH_W         = 5;
   localparam int REQ_DATA_W      = 32;
   localparam int RSP_DATA_W      = 40;

   // Operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH  = 4'd0,
      MODE_POP   = 4'd1,
      MODE_TOP   = 4'd2,
      MODE_DUP   = 4'd3,
      MODE_SWAP  = 4'd4,
      MODE_OVER  = 4'd5,
      MODE_ROT   = 4'd6,
      MODE_DROP  = 4'd7,
      MODE_CLEAR = 4'd8
   } mode_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_RD1,
      S_RD2,
      S_RD3,
      S_RD4,
      S_WR1,
      S_WR2,
      S_WR3,
      S_DONE
   } state_type;

   // Stack entry relative to the current depth n
   typedef enum logic [1:0] {
      OFS_N0,   // n
      OFS_N1,   // n-1
      OFS_N2,   // n-2
      OFS_N3    // n-3
   } ofs_type;

   // Capture register for the registered read data
   typedef enum logic [1:0] {
      CAP_NONE,
      CAP_A,
      CAP_B,
      CAP_C
   } cap_type;

   // Write data source
   typedef enum logic [1:0] {
      SRC_VALUE,
      SRC_A,
      SRC_B,
      SRC_C
   } src_type;

   // Result word select
   typedef enum logic [2:0] {
      OUT_ZERO,
      OUT_VALUE,
      OUT_A,
      OUT_B,
      OUT_C
   } out_sel_type;

   // Depth update
   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLR
   } cnt_op_type;

   // Command bundle from the controller to the datapath
   typedef struct packed {
      logic        load;
      ofs_type     rd_ofs;
      cap_type     cap;
      logic        wr_en;
      ofs_type     wr_ofs;
      src_type     wr_src;
      logic        commit;
      out_sel_type out_sel;
      cnt_op_type  cnt_op;
      status_type  status;
   } ctl_cmd_type;

   // Number of entries an operation consumes
   function automatic logic [1:0] op_need(input logic [MODE_W-1:0] mode);
      logic [1:0] need;
      unique case (mode)
         MODE_POP, MODE_TOP, MODE_DUP, MODE_DROP: need = 2'd1;
         MODE_SWAP, MODE_OVER:                    need = 2'd2;
         MODE_ROT:                                need = 2'd3;
         default:                                 need = 2'd0;
      endcase
      return need;
   endfunction

   // Operations that add one entry
   function automatic logic op_grows(input logic [MODE_W-1:0] mode);
      return (mode == MODE_PUSH) || (mode == MODE_DUP) || (mode == MODE_OVER);
   endfunction

endpackage

@@ sv/forth_data_stack.sv @@
// Forth data stack top level: a request steps through the read, write and S_DONE states, and a
// new one is taken only back in S_IDLE; the three top entries are fetched one after another
// through the single registered read port of the stack memory, then up to three entries are
// written. The result register lets a new request be taken while the previous result waits;
// the next result then holds in its last state until the waiting one is taken.
// Reset empties the stack and drops any waiting result; memory contents are not cleared.
module forth_data_stack #(
   parameter int STACK_DEPTH = fds_pkg::STACK_DEPTH_DEF,
   parameter int WORD_WIDTH  = fds_pkg::WORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fds_pkg::REQ_DATA_W-1:0]    req_tdata,  // push_value[31:0]
   input  logic [fds_pkg::MODE_W-1:0]        req_tuser,  // mode[3:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fds_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // data_out[31:0], depth[36:32], zero pad
   output logic [fds_pkg::STATUS_W-1:0]      rsp_tuser   // status[1:0]
);
   import fds_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);

   ctl_cmd_type              cmd;
   logic [CW-1:0]            count;
   logic signed [DATA_W-1:0] rsp_data;
   logic [STATUS_W-1:0]      rsp_status;
   logic [DEPTH_W-1:0]       rsp_depth;

   fds_controller #(
      .STACK_DEPTH (STACK_DEPTH),
      .CW          (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .count      (count),
      .cmd        (cmd)
   );

   fds_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .WORD_WIDTH  (WORD_WIDTH),
      .CW          (CW)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .push_value (req_tdata),
      .count      (count),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status),
      .rsp_depth  (rsp_depth)
   );

   // Pack the result
   assign rsp_tdata = {(RSP_DATA_W - DEPTH_W - DATA_W)'(0), rsp_depth, rsp_data};
   assign rsp_tuser = rsp_status;

   // Depth never passes the configured capacity
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   // Overflow is reported only on a full stack
   a_over_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_status == ST_OVER)) |-> (rsp_depth == DEPTH_W'(STACK_DEPTH)))
      else $error("overflow reported below capacity");

   // Underflow is reported only with fewer than three entries
   a_under_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_status == ST_UNDER)) |-> (rsp_depth < DEPTH_W'(3)))
      else $error("underflow reported with three or more entries");

   // Depth changes only when a result is committed
   a_count_commit: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(count))
      else $error("depth changed outside commit");

endmodule

@@ sv/fds_datapath.sv @@
// Datapath of the Forth data stack: stack memory, fetch registers, depth and result registers.
// Depends on fds_pkg; driven by fds_controller through ctl_cmd_type.
module fds_datapath #(
   parameter int STACK_DEPTH = fds_pkg::STACK_DEPTH_DEF,
   parameter int WORD_WIDTH  = fds_pkg::WORD_WIDTH_DEF,
   parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fds_pkg::ctl_cmd_type               cmd,
   input  logic signed [fds_pkg::DATA_W-1:0]  push_value,
   output logic [CW-1:0]                      count,
   output logic signed [fds_pkg::DATA_W-1:0]  rsp_data,
   output logic [fds_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fds_pkg::DEPTH_W-1:0]        rsp_depth
);
   import fds_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);

   typedef logic signed [WORD_WIDTH-1:0] word_type;

   word_type mem [STACK_DEPTH];

   word_type             value_ff;
   word_type             a_ff;
   word_type             b_ff;
   word_type             c_ff;
   word_type             rd_q_ff;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic signed [DATA_W-1:0] rsp_data_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [DEPTH_W-1:0]   rsp_depth_ff;

   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   word_type             wr_data;
   word_type             out_word;

   // Map an offset below the current depth to a memory address
   function automatic logic [AW-1:0] ofs_addr(input logic [CW-1:0] n, input ofs_type ofs);
      logic [CW-1:0] idx;
      case (ofs)
         OFS_N0:  idx = n;
         OFS_N1:  idx = n - CW'(1);
         OFS_N2:  idx = n - CW'(2);
         default: idx = n - CW'(3);
      endcase
      return AW'(idx);
   endfunction

   assign rd_addr = ofs_addr(count_ff, cmd.rd_ofs);
   assign wr_addr = ofs_addr(count_ff, cmd.wr_ofs);

   // Select write data
   always_comb begin
      case (cmd.wr_src)
         SRC_VALUE: wr_data = value_ff;
         SRC_A:     wr_data = a_ff;
         SRC_B:     wr_data = b_ff;
         default:   wr_data = c_ff;
      endcase
   end

   // Stack memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // Latch the pushed word and the fetched entries
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= WORD_WIDTH'(push_value);
      end
      case (cmd.cap)
         CAP_A:   a_ff <= rd_q_ff;
         CAP_B:   b_ff <= rd_q_ff;
         CAP_C:   c_ff <= rd_q_ff;
         default: ;
      endcase
   end

   // Next depth
   always_comb begin
      count_in = count_ff;
      if (cmd.commit) begin
         case (cmd.cnt_op)
            CNT_INC: count_in = count_ff + CW'(1);
            CNT_DEC: count_in = count_ff - CW'(1);
            CNT_CLR: count_in = '0;
            default: count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Select the result word
   always_comb begin
      case (cmd.out_sel)
         OUT_VALUE: out_word = value_ff;
         OUT_A:     out_word = a_ff;
         OUT_B:     out_word = b_ff;
         OUT_C:     out_word = c_ff;
         default:   out_word = '0;
      endcase
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff   <= DATA_W'(out_word);
         rsp_status_ff <= cmd.status;
         rsp_depth_ff  <= DEPTH_W'(count_in);
      end
   end

   assign count      = count_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_depth  = rsp_depth_ff;

endmodule

@@ sv/fds_controller.sv @@
// Sequencer of the Forth data stack: accepts requests, checks depth, steps fetches and writes.
// Depends on fds_pkg; commands fds_datapath through ctl_cmd_type.
module fds_controller #(
   parameter int STACK_DEPTH = fds_pkg::STACK_DEPTH_DEF,
   parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [fds_pkg::MODE_W-1:0]  req_mode,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [CW-1:0]               count,
   output fds_pkg::ctl_cmd_type        cmd
);
   import fds_pkg::*;

   state_type         state_ff;
   state_type         state_in;
   logic [MODE_W-1:0] mode_ff;
   status_type        status_ff;
   status_type        status_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              accept;
   logic              out_free;
   logic              is_ok;
   logic              has_top;

   assign accept   = (state_ff == S_IDLE) && req_tvalid;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_ok    = (status_ff == ST_OK);
   assign has_top  = (count != '0);

   // Check depth against what the request consumes and adds
   always_comb begin
      if (count < CW'(op_need(req_mode))) begin
         status_in = ST_UNDER;
      end else if (op_grows(req_mode) && (count >= CW'(STACK_DEPTH))) begin
         status_in = ST_OVER;
      end else begin
         status_in = ST_OK;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_RD1;
         S_RD1:   state_in = S_RD2;
         S_RD2:   state_in = S_RD3;
         S_RD3:   state_in = S_RD4;
         S_RD4:   state_in = S_WR1;
         S_WR1:   state_in = S_WR2;
         S_WR2:   state_in = S_WR3;
         S_WR3:   state_in = S_DONE;
         S_DONE:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd        = '0;
      cmd.status = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_tvalid;
         end
         S_RD1: begin
            cmd.rd_ofs = OFS_N1;
         end
         S_RD2: begin
            cmd.rd_ofs = OFS_N2;
            cmd.cap    = CAP_A;
         end
         S_RD3: begin
            cmd.rd_ofs = OFS_N3;
            cmd.cap    = CAP_B;
         end
         S_RD4: begin
            cmd.cap = CAP_C;
         end
         S_WR1: begin
            if (is_ok) begin
               case (mode_ff)
                  MODE_PUSH: begin
                     cmd.wr_en = 1'b1; cmd.wr_ofs = OFS_N0; cmd.wr_src = SRC_VALUE;
                  end
                  MODE_DUP: begin
                     cmd.wr_en = 1'b1; cmd.wr_ofs = OFS_N0; cmd.wr_src = SRC_A;
                  end
                  MODE_OVER: begin
                     cmd.wr_en = 1'b1; cmd.wr_ofs = OFS_N0; cmd.wr_src = SRC_B;
                  end
                  MODE_SWAP: begin
                     cmd.wr_en = 1'b1; cmd.wr_ofs = OFS_N1; cmd.wr_src = SRC_B;
                  end
                  MODE_ROT: begin
                     cmd.wr_en = 1'b1; cmd.wr_ofs = OFS_N3; cmd.wr_src = SRC_B;
                  end
                  default: ;
               endcase
            end
         end
         S_WR2: begin
            if (is_ok && ((mode_ff == MODE_SWAP) || (mode_ff == MODE_ROT))) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_ofs = OFS_N2;
               cmd.wr_src = SRC_A;
            end
         end
         S_WR3: begin
            if (is_ok && (mode_ff == MODE_ROT)) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_ofs = OFS_N1;
               cmd.wr_src = SRC_C;
            end
         end
         S_DONE: begin
            cmd.commit  = out_free;
            cmd.out_sel = has_top ? OUT_A : OUT_ZERO;
            cmd.cnt_op  = CNT_HOLD;
            if (is_ok) begin
               unique case (mode_ff)
                  MODE_PUSH: begin
                     cmd.out_sel = OUT_VALUE; cmd.cnt_op = CNT_INC;
                  end
                  MODE_POP: begin
                     cmd.out_sel = OUT_A; cmd.cnt_op = CNT_DEC;
                  end
                  MODE_TOP:  cmd.out_sel = OUT_A;
                  MODE_DUP: begin
                     cmd.out_sel = OUT_A; cmd.cnt_op = CNT_INC;
                  end
                  MODE_SWAP: cmd.out_sel = OUT_B;
                  MODE_OVER: begin
                     cmd.out_sel = OUT_B; cmd.cnt_op = CNT_INC;
                  end
                  MODE_ROT:  cmd.out_sel = OUT_C;
                  MODE_DROP: begin
                     // new top is the second entry when one remains
                     cmd.out_sel = (count >= CW'(2)) ? OUT_B : OUT_ZERO;
                     cmd.cnt_op  = CNT_DEC;
                  end
                  MODE_CLEAR: begin
                     cmd.out_sel = OUT_ZERO; cmd.cnt_op = CNT_CLR;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   // Result valid: set on commit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold the request's mode and status for the whole sequence
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_mode;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ tb/forth_data_stack_check.sv @@
// Response checker for the Forth data stack: keeps its own copy of the stack,
// queues the response that each accepted request should produce and compares it
// with every accepted response. Depends on fds_pkg for codes and channel widths.
module forth_data_stack_check #(
   parameter int STACK_DEPTH = fds_pkg::STACK_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [fds_pkg::REQ_DATA_W-1:0] req_tdata,   // push_value[31:0]
   input  logic [fds_pkg::MODE_W-1:0]     req_tuser,   // mode[3:0]
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [fds_pkg::RSP_DATA_W-1:0] rsp_tdata,   // data_out[31:0], depth[36:32], zero pad
   input  logic [fds_pkg::STATUS_W-1:0]   rsp_tuser,   // status[1:0]
   output int                             fail_count,
   output int                             pending,
   output int                             checked,
   output int                             under_seen,
   output int                             over_seen
);
   import fds_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0]  data;
      status_type         status;
      logic [DEPTH_W-1:0] depth;
   } stack_rsp_type;

   logic [DATA_W-1:0] words [STACK_DEPTH];
   int unsigned       depth_q     = 0;
   stack_rsp_type     rsp_expected [$];
   int                errors      = 0;
   int                rsp_count   = 0;
   int                under_count = 0;
   int                over_count  = 0;

   // Apply one operation to the mirrored stack and return the response it gives
   function automatic stack_rsp_type apply_stack_op(input logic [MODE_W-1:0] mode,
                                                    input logic [DATA_W-1:0] value);
      stack_rsp_type     r;
      int unsigned       n;
      int unsigned       need;
      bit                grows;
      logic [DATA_W-1:0] hold;
      logic [DATA_W-1:0] popped;
      n      = depth_q;
      need   = 0;
      grows  = 1'b0;
      popped = '0;
      case (mode)
         MODE_PUSH:                     grows = 1'b1;
         MODE_POP, MODE_TOP, MODE_DROP: need = 1;
         MODE_DUP: begin
            need  = 1;
            grows = 1'b1;
         end
         MODE_SWAP:                     need = 2;
         MODE_OVER: begin
            need  = 2;
            grows = 1'b1;
         end
         MODE_ROT:                      need = 3;
         default:                       need = 0;
      endcase

      // Underflow is tested before overflow
      r.status = ST_OK;
      if (n < need) begin
         r.status = ST_UNDER;
      end else if (grows && n >= STACK_DEPTH) begin
         r.status = ST_OVER;
      end

      if (r.status == ST_OK) begin
         case (mode)
            MODE_PUSH: begin
               words[n] = value;
               depth_q  = n + 1;
            end
            MODE_POP: begin
               popped  = words[n-1];
               depth_q = n - 1;
            end
            MODE_DUP: begin
               words[n] = words[n-1];
               depth_q  = n + 1;
            end
            MODE_SWAP: begin
               hold       = words[n-1];
               words[n-1] = words[n-2];
               words[n-2] = hold;
            end
            MODE_OVER: begin
               words[n] = words[n-2];
               depth_q  = n + 1;
            end
            MODE_ROT: begin
               // ( x1 x2 x3 -- x2 x3 x1 )
               hold       = words[n-3];
               words[n-3] = words[n-2];
               words[n-2] = words[n-1];
               words[n-1] = hold;
            end
            MODE_DROP:  depth_q = n - 1;
            MODE_CLEAR: depth_q = 0;
            default:    depth_q = n;
         endcase
      end

      // Pop reports the removed word; everything else reports the new top or zero
      if (mode == MODE_POP && r.status == ST_OK) begin
         r.data = popped;
      end else begin
         r.data = (depth_q == 0) ? '0 : words[depth_q-1];
      end
      r.depth = depth_q[DEPTH_W-1:0];
      return r;
   endfunction

   // Check responses first, then record new requests, so a same-edge pair stays ordered
   always @(posedge clock) begin
      stack_rsp_type got;
      stack_rsp_type want;
      if (reset) begin
         depth_q = 0;
         rsp_expected.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.data   = rsp_tdata[DATA_W-1:0];
            got.depth  = rsp_tdata[DATA_W +: DEPTH_W];
            got.status = status_type'(rsp_tuser);
            rsp_count++;
            if (got.status == ST_UNDER) under_count++;
            if (got.status == ST_OVER) over_count++;
            if (rsp_expected.size() == 0) begin
               if (errors < 10) begin
                  $display("unexpected response: data %h status %0d depth %0d",
                           got.data, got.status, got.depth);
               end
               errors++;
            end else begin
               want = rsp_expected.pop_front();
               if (got !== want) begin
                  if (errors < 10) begin
                     $display("response mismatch: data %h/%h status %0d/%0d depth %0d/%0d",
                              want.data, got.data, want.status, got.status,
                              want.depth, got.depth);
                  end
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            rsp_expected = {rsp_expected, apply_stack_op(req_tuser, req_tdata[DATA_W-1:0])};
         end
      end
      fail_count <= errors;
      pending    <= rsp_expected.size();
      checked    <= rsp_count;
      under_seen <= under_count;
      over_seen  <= over_count;
   end

endmodule

@@ tb/forth_data_stack_test.sv @@
// Top of the Forth data stack testbench: clock, reset, request stimulus with random
// gaps, random response stalls and the verdict. Depends on fds_pkg, forth_data_stack
// and forth_data_stack_check.
module forth_data_stack_test;
   import fds_pkg::*;

   localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'd15;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // push_value[31:0]
   logic [MODE_W-1:0]     req_tuser  = '0;   // mode[3:0]
   logic                  rsp_tready = 1'b0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // data_out[31:0], depth[36:32], zero pad
   logic [STATUS_W-1:0]   rsp_tuser;         // status[1:0]

   int fail_count;
   int pending;
   int checked;
   int under_seen;
   int over_seen;
   int cycles     = 0;
   int sent       = 0;
   int stall_left = 0;
   bit no_idle    = 1'b0;

   forth_data_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .WORD_WIDTH  (WORD_WIDTH_DEF)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   forth_data_stack_check #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .under_seen (under_seen),
      .over_seen  (over_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly short idle stretches, a few long ones, none during a quiet stretch
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 9);
      return $urandom_range(15, 40);
   endfunction

   // Favor the extreme words now and then
   function automatic logic [REQ_DATA_W-1:0] pick_word();
      if ($urandom_range(0, 99) < 20) begin
         case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   // Lean toward growing ops while filling and toward shrinking ops while draining
   function automatic logic [MODE_W-1:0] pick_mode(input bit filling);
      int unsigned r;
      int unsigned grow_pct;
      r        = $urandom_range(0, 99);
      grow_pct = filling ? 70 : 25;
      if (r < 2) return MODE_CLEAR;
      if (r < 5) return MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      if (r < grow_pct) begin
         case ($urandom_range(0, 4))
            0, 1, 2: return MODE_PUSH;
            3:       return MODE_DUP;
            default: return MODE_OVER;
         endcase
      end
      case ($urandom_range(0, 4))
         0:       return MODE_POP;
         1:       return MODE_TOP;
         2:       return MODE_SWAP;
         3:       return MODE_ROT;
         default: return MODE_DROP;
      endcase
   endfunction

   // Hold the request until the block takes it
   task automatic send_request(input logic [MODE_W-1:0] mode,
                               input logic [REQ_DATA_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      do @(posedge clock); while (req_tready !== 1'b1);
      sent++;
   endtask

   // Stall the response side at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
         $display("forth_data_stack_test: errors");
         $finish;
      end
   end

   initial begin
      bit filling;
      int phase_left;
      int idle_left;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Every op on an empty stack, then SWAP and ROT one entry short and with just enough entries
      send_request(MODE_POP, pick_word());
      send_request(MODE_TOP, pick_word());
      send_request(MODE_DUP, pick_word());
      send_request(MODE_SWAP, pick_word());
      send_request(MODE_OVER, pick_word());
      send_request(MODE_ROT, pick_word());
      send_request(MODE_DROP, pick_word());
      send_request(MODE_CLEAR, pick_word());
      send_request(MODE_UNUSED_LO, pick_word());
      send_request(MODE_PUSH, 32'h8000_0000);
      send_request(MODE_SWAP, pick_word());
      send_request(MODE_PUSH, 32'h7FFF_FFFF);
      send_request(MODE_ROT, pick_word());
      send_request(MODE_SWAP, pick_word());
      send_request(MODE_OVER, pick_word());
      send_request(MODE_ROT, pick_word());
      send_request(MODE_DUP, pick_word());
      send_request(MODE_TOP, pick_word());
      send_request(MODE_UNUSED_HI, pick_word());
      send_request(MODE_POP, pick_word());
      send_request(MODE_DROP, pick_word());
      send_request(MODE_PUSH, 32'hFFFF_FFFF);
      send_request(MODE_PUSH, 32'h0000_0000);
      send_request(MODE_CLEAR, pick_word());
      send_request(MODE_POP, pick_word());

      // Alternate fill and drain phases so the stack swings between empty and full
      filling    = 1'b1;
      phase_left = $urandom_range(25, 50);
      idle_left  = $urandom_range(40, 120);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (phase_left == 0) begin
            filling    = !filling;
            phase_left = $urandom_range(15, 50);
         end
         phase_left--;
         if (idle_left == 0) begin
            no_idle   = !no_idle;
            idle_left = no_idle ? $urandom_range(10, 40) : $urandom_range(40, 120);
         end
         idle_left--;
         send_request(pick_mode(filling), pick_word());
      end
      req_tvalid <= 1'b0;
      no_idle = 1'b0;

      // Wait out the outstanding responses and let the pipeline settle
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d requests, checked %0d responses in %0d cycles",
               sent, checked, cycles);
      $display("responses with underflow: %0d, with overflow: %0d, mismatches: %0d",
               under_seen, over_seen, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("forth_data_stack_test: clean");
      end else begin
         $display("forth_data_stack_test: errors");
      end
      $finish;
   end

endmodule
